// File: rtl/core/dts_pkg.sv
// Shared types and constants for the digit-driven table shuffle.
package dts_pkg;

    // Item actions carried in the input transaction.
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DIGIT = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    // Table read address sources.
    typedef enum logic [1:0] {
        RD_INDEX = 2'd0,
        RD_POS   = 2'd1,
        RD_SWAP  = 2'd2
    } t_rd_sel;

    // Input transaction payload.
    typedef struct packed {
        t_action     action;
        logic [3:0]  digit;
        logic [7:0]  read_index;
    } t_dts_in;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0]  entry_value;
        logic        draw_accepted;
        logic        draw_rejected;
        logic        shuffle_done;
        logic [8:0]  current_position;
    } t_dts_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    take;
        logic    start;
        logic    gather;
        logic    div_step;
        logic    reject;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_entry;
        logic    cap_swap;
        logic    wr_pos;
        logic    wr_swap;
        logic    emit;
    } t_dts_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    digit_live;
        logic    draw_full;
        logic    div_last;
        logic    draw_ok;
        logic    out_free;
    } t_dts_sts;

    // Fixed widths and constants.
    localparam int POS_W     = 9;
    localparam int ACC_W     = 10;
    localparam int DIV_STEPS = ACC_W;
    localparam logic [3:0]  MAX_DIGIT  = 4'd9;
    localparam logic [8:0]  MOD_ONE    = 9'd10;
    localparam logic [8:0]  MOD_TWO    = 9'd100;
    localparam logic [10:0] RANGE_ONE  = 11'd10;
    localparam logic [10:0] RANGE_TWO  = 11'd100;
    localparam logic [10:0] RANGE_THR  = 11'd1000;
    localparam logic [8:0]  SIZE_MIN   = 9'd2;
    localparam logic [8:0]  SIZE_RESET = 9'd256;

endpackage

// File: rtl/core/dts_ctrl.sv
// Controller state machine that sequences each transaction of the shuffle.
module dts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dts_pkg::t_dts_sts i_sts,
    output logic              o_in_stall,
    output dts_pkg::t_dts_cmd o_cmd
);
    import dts_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_RDWAIT = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_RDJ    = 9'b000100000,
        S_WRP    = 9'b001000000,
        S_WRJ    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.action)
                    ACT_START: begin
                        o_cmd.start = 1'b1;
                    end
                    ACT_DIGIT: begin
                        if (i_sts.digit_live) begin
                            o_cmd.gather = 1'b1;
                            if (i_sts.draw_full) begin
                                n_state = S_DIV;
                            end
                        end
                    end
                    ACT_READ: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_INDEX;
                        n_state      = S_RDWAIT;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.cap_entry = 1'b1;
                n_state         = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.draw_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_POS;
                    n_state      = S_RDJ;
                end else begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_RDJ: begin
                // Entry at the position is on the read port; fetch the partner.
                o_cmd.cap_swap = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_SWAP;
                n_state        = S_WRP;
            end
            S_WRP: begin
                o_cmd.wr_pos = 1'b1;
                n_state      = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.wr_swap = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/core/dts_dpath.sv
// Datapath: shuffle state, digit gathering, remainder unit, table memory and output register.
module dts_dpath #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dts_pkg::t_dts_in  i_in_data,
    input  logic              i_out_stall,
    input  logic              i_cfg_wr_en,
    input  logic [8:0]        i_cfg_wr_data,
    input  dts_pkg::t_dts_cmd i_cmd,
    output dts_pkg::t_dts_sts o_sts,
    output logic              o_out_valid,
    output dts_pkg::t_dts_out o_out_data
);
    import dts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [POS_W-1:0] DEPTH_W = POS_W'(TABLE_DEPTH);

    // Control state.
    logic [8:0]              r_size;
    logic [POS_W-1:0]        r_pos;
    logic [ACC_W-1:0]        r_acc;
    logic [1:0]              r_gath;
    logic                    r_fin;
    logic [TABLE_DEPTH-1:0]  r_vld;
    logic                    r_out_vld;

    // Payload state.
    t_dts_in                 r_item;
    logic [ACC_W-1:0]        r_x;
    logic [POS_W-1:0]        r_rem;
    logic [ACC_W-1:0]        r_dvd;
    logic [3:0]              r_dcnt;
    logic [7:0]              r_tp;
    logic [7:0]              r_entry;
    logic                    r_acc_f;
    logic                    r_rej_f;
    t_dts_out                r_out;
    logic [7:0]              r_mem [TABLE_DEPTH];
    logic [7:0]              r_mem_q;
    logic                    r_rd_vld;
    logic [AW-1:0]           r_rd_addr;

    // Next values and helpers.
    logic [POS_W-1:0]        eff_size;
    logic [POS_W-1:0]        modulus;
    logic [1:0]              need;
    logic [10:0]             range_lim;
    logic [ACC_W-1:0]        n_acc;
    logic [1:0]              n_gath;
    logic [POS_W-1:0]        n_pos;
    logic [ACC_W-1:0]        div_trial;
    logic                    div_ge;
    logic [POS_W-1:0]        n_rem;
    logic [10:0]             draw_top;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rd_val;
    logic                    idx_in_range;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [7:0]              mem_wd;

    // Effective table size, clamped to the usable range.
    always_comb begin
        if (r_size < SIZE_MIN) begin
            eff_size = SIZE_MIN;
        end else if (r_size > DEPTH_W) begin
            eff_size = DEPTH_W;
        end else begin
            eff_size = r_size;
        end
    end

    // Modulus for the current position and the digit count and range it calls for.
    assign modulus = r_pos + POS_W'(1);
    always_comb begin
        if (modulus <= MOD_ONE) begin
            need      = 2'd1;
            range_lim = RANGE_ONE;
        end else if (modulus <= MOD_TWO) begin
            need      = 2'd2;
            range_lim = RANGE_TWO;
        end else begin
            need      = 2'd3;
            range_lim = RANGE_THR;
        end
    end

    // Digit gathering: accumulator times ten plus the new digit.
    assign n_acc  = ACC_W'({r_acc, 3'b000} + {r_acc, 1'b0} + ACC_W'(r_item.digit));
    assign n_gath = r_gath + 2'd1;
    assign n_pos  = r_pos + POS_W'(1);

    // One restoring remainder step per cycle.
    assign div_trial = {r_rem, r_dvd[ACC_W-1]};
    assign div_ge    = (div_trial >= {1'b0, modulus});
    assign n_rem     = div_ge ? POS_W'(div_trial - {1'b0, modulus}) : div_trial[POS_W-1:0];

    // The draw is unbiased when the next multiple of the modulus stays within the range.
    assign draw_top = 11'(r_x) - 11'(r_rem) + 11'(modulus);

    // Table read port address.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_INDEX: rd_addr = r_item.read_index[AW-1:0];
            RD_POS:   rd_addr = r_pos[AW-1:0];
            RD_SWAP:  rd_addr = r_rem[AW-1:0];
            default:  rd_addr = r_pos[AW-1:0];
        endcase
    end

    // An entry never written since start reads as its own index.
    assign rd_val       = r_rd_vld ? r_mem_q : 8'(r_rd_addr);
    assign idx_in_range = ({1'b0, r_item.read_index} < DEPTH_W);

    // Table write port: the position entry first, then its partner.
    assign mem_we = i_cmd.wr_pos | i_cmd.wr_swap;
    assign mem_wa = i_cmd.wr_swap ? r_rem[AW-1:0] : r_pos[AW-1:0];
    assign mem_wd = i_cmd.wr_swap ? r_tp : rd_val;

    // Table memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_mem_q   <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // Written flags for the table; reset and start restore the identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_wa] <= 1'b1;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // Shuffle control state: position, gathering and finished flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_W'(1);
            r_acc  <= '0;
            r_gath <= '0;
            r_fin  <= 1'b0;
        end else if (i_cmd.take) begin
            // A lowered size can finish the shuffle before this transaction.
            r_fin <= r_fin | (r_pos >= eff_size);
        end else if (i_cmd.start) begin
            r_pos  <= POS_W'(1);
            r_acc  <= '0;
            r_gath <= '0;
            r_fin  <= 1'b0;
        end else if (i_cmd.gather) begin
            if (n_gath >= need) begin
                r_acc  <= '0;
                r_gath <= '0;
            end else begin
                r_acc  <= n_acc;
                r_gath <= n_gath;
            end
        end else if (i_cmd.wr_swap) begin
            r_pos <= n_pos;
            if (n_pos >= eff_size) begin
                r_fin <= 1'b1;
            end
        end
    end

    // Transaction payload, remainder unit and swap holding register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item  <= i_in_data;
            r_entry <= '0;
            r_acc_f <= 1'b0;
            r_rej_f <= 1'b0;
        end
        if (i_cmd.gather) begin
            r_x    <= n_acc;
            r_dvd  <= n_acc;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[ACC_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + 4'd1;
        end
        if (i_cmd.reject) begin
            r_rej_f <= 1'b1;
        end
        if (i_cmd.cap_entry) begin
            r_entry <= idx_in_range ? rd_val : 8'd0;
        end
        if (i_cmd.cap_swap) begin
            r_tp <= rd_val;
        end
        if (i_cmd.wr_swap) begin
            r_acc_f <= 1'b1;
        end
    end

    // Output register; it frees up when the receiver takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.entry_value      <= r_entry;
            r_out.draw_accepted    <= r_acc_f;
            r_out.draw_rejected    <= r_rej_f;
            r_out.shuffle_done     <= r_fin;
            r_out.current_position <= r_pos;
        end
    end

    // Status back to the controller.
    assign o_sts.action     = r_item.action;
    assign o_sts.digit_live = !r_fin && (r_item.digit <= MAX_DIGIT);
    assign o_sts.draw_full  = (n_gath >= need);
    assign o_sts.div_last   = (r_dcnt == 4'(DIV_STEPS - 1));
    assign o_sts.draw_ok    = (draw_top <= range_lim);
    assign o_sts.out_free   = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/digit_driven_table_shuffle.sv
// Top level of the digit-driven table shuffle (Fisher-Yates with rejection sampling).
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_stall       i_in_data  (action, digit, read_index)
//   output    out        o_out_valid / i_out_stall     o_out_data (entry, flags, position)
//   config    in         i_cfg_wr_en                   i_cfg_wr_data (table_size)
//
// One transaction is in work at a time; the next is taken once the result is in the
// output register. A read waits for the registered table read before its capture.
// A digit that completes a draw runs a 10-step remainder loop, one bit per cycle,
// then checks the range; a rejection ends there, and an acceptance goes on to
// a read-read-write-write swap on the table's one read port and one write port.
// Reset is synchronous and active low and leaves an identity table; no clearing pass.
// A stalled output holds its transaction; the block keeps working on the next one.
module digit_driven_table_shuffle #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dts_pkg::t_dts_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dts_pkg::t_dts_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [8:0]        i_cfg_wr_data
);
    import dts_pkg::*;

    t_dts_cmd cmd;
    t_dts_sts sts;

    // Sequencer.
    dts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Table, arithmetic and output register.
    dts_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

// File: rtl/core/dts_checker.sv
// Port-level checker for the digit-driven table shuffle, bound to the top level.
module dts_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  dts_pkg::t_dts_out o_out_data
);
    import dts_pkg::*;

    // A stalled output transaction stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // A reset leaves no output transaction pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // After taking a transaction the block is busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // An accepted draw never carries a rejection or a table entry.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.draw_accepted |->
            !o_out_data.draw_rejected && (o_out_data.entry_value == 8'd0))
        else $error("inconsistent draw flags");

endmodule

bind digit_driven_table_shuffle dts_checker u_dts_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the digit-driven table shuffle.
`timescale 1ns / 1ps

module testbench;
    import dts_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_dts_in    in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_dts_out   out_data;
    logic       cfg_wr_en = 1'b0;
    logic [8:0] cfg_wr_data = '0;

    // Shadow copy of the shuffle state and the size register.
    logic [7:0] shuffle_table [256];
    logic [8:0] cur_pos;
    logic [9:0] draw_sum;
    logic [1:0] draw_digits;
    logic       done_flag;
    logic [8:0] size_model;

    t_dts_in    pending_items[$];
    t_dts_out   expected_results[$];
    t_dts_out   want_result;
    int         fail_count = 0;
    bit         steady_run = 1'b0;

    digit_driven_table_shuffle dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Put the shadow table back to identity and clear the draw progress.
    function automatic void restart_model();
        for (int k = 0; k < 256; k++) begin
            shuffle_table[k] = k[7:0];
        end
        cur_pos     = 9'd1;
        draw_sum    = '0;
        draw_digits = '0;
        done_flag   = 1'b0;
    endfunction

    // Work out the result of one transaction and advance the shadow state.
    function automatic t_dts_out shuffle_predict(input t_dts_in item);
        t_dts_out   res;
        int         eff;
        int         m;
        int         need;
        int         span;
        int         x;
        int         j;
        logic [7:0] held;
        res = '0;
        eff = int'(size_model);
        if (eff < 2) eff = 2;
        if (eff > 256) eff = 256;
        // A size lowered below the position ends the shuffle before the item.
        if (!done_flag && cur_pos >= eff) done_flag = 1'b1;
        case (item.action)
            ACT_START: begin
                restart_model();
            end
            ACT_DIGIT: begin
                if (!done_flag && item.digit <= MAX_DIGIT) begin
                    m    = int'(cur_pos) + 1;
                    need = (m <= 10) ? 1 : ((m <= 100) ? 2 : 3);
                    span = (need == 1) ? 10 : ((need == 2) ? 100 : 1000);
                    x = int'(draw_sum) * 10 + int'(item.digit);
                    draw_sum    = x[9:0];
                    draw_digits = draw_digits + 2'd1;
                    if (int'(draw_digits) >= need) begin
                        x = int'(draw_sum);
                        draw_sum    = '0;
                        draw_digits = '0;
                        if (x < m * (span / m)) begin
                            j = x % m;
                            held = shuffle_table[cur_pos[7:0]];
                            shuffle_table[cur_pos[7:0]] = shuffle_table[j];
                            shuffle_table[j] = held;
                            cur_pos = cur_pos + 9'd1;
                            res.draw_accepted = 1'b1;
                            if (cur_pos >= eff) done_flag = 1'b1;
                        end else begin
                            res.draw_rejected = 1'b1;
                        end
                    end
                end
            end
            ACT_READ: begin
                res.entry_value = shuffle_table[item.read_index];
            end
            default: begin
            end
        endcase
        res.shuffle_done     = done_flag;
        res.current_position = cur_pos;
        return res;
    endfunction

    function automatic t_dts_in make_item(t_action act, logic [3:0] dig, logic [7:0] idx);
        t_dts_in it;
        it.action     = act;
        it.digit      = dig;
        it.read_index = idx;
        return it;
    endfunction

    // Driver: present pending items, predict each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                expected_results.push_back(shuffle_predict(in_data));
            end
            if (pending_items.size() > 0 && (steady_run || $urandom_range(99) >= 24)) begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted output transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected output transaction: %p", out_data);
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (out_data.entry_value !== want_result.entry_value) begin
                        $error("entry_value: expected %0d, actual %0d",
                               want_result.entry_value, out_data.entry_value);
                        fail_count++;
                    end
                    if (out_data.draw_accepted !== want_result.draw_accepted) begin
                        $error("draw_accepted: expected %0d, actual %0d",
                               want_result.draw_accepted, out_data.draw_accepted);
                        fail_count++;
                    end
                    if (out_data.draw_rejected !== want_result.draw_rejected) begin
                        $error("draw_rejected: expected %0d, actual %0d",
                               want_result.draw_rejected, out_data.draw_rejected);
                        fail_count++;
                    end
                    if (out_data.shuffle_done !== want_result.shuffle_done) begin
                        $error("shuffle_done: expected %0d, actual %0d",
                               want_result.shuffle_done, out_data.shuffle_done);
                        fail_count++;
                    end
                    if (out_data.current_position !== want_result.current_position) begin
                        $error("current_position: expected %0d, actual %0d",
                               want_result.current_position, out_data.current_position);
                        fail_count++;
                    end
                end
            end
            out_stall <= !steady_run && ($urandom_range(99) < 24);
        end
    end

    // Wait until no item is queued, in flight or awaiting its result.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // Write the table size register once the block is idle.
    task automatic write_table_size(input logic [8:0] size_val);
        wait_drained();
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size_val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        size_model = size_val;
        @(negedge i_clk);
    endtask

    // One shuffle run: set the size, start, then feed random digits with some noise
    // until the shuffle finishes or the digit cap is reached.
    task automatic shuffle_phase(input logic [8:0] size_val, input int digit_cap);
        int n;
        int r;
        write_table_size(size_val);
        pending_items.push_back(make_item(ACT_START, 4'($urandom_range(15)),
                                          8'($urandom_range(255))));
        wait_drained();
        n = 0;
        while (!done_flag && n < digit_cap) begin
            @(negedge i_clk);
            if (pending_items.size() < 2) begin
                r = $urandom_range(99);
                if (r < 7) begin
                    pending_items.push_back(make_item(ACT_DIGIT, 4'($urandom_range(15, 10)),
                                                      8'($urandom_range(255))));
                end else if (r < 13) begin
                    pending_items.push_back(make_item(ACT_READ, 4'($urandom_range(15)),
                                                      8'($urandom_range(255))));
                end else if (r < 15) begin
                    pending_items.push_back(make_item(ACT_NOP, 4'($urandom_range(15)),
                                                      8'($urandom_range(255))));
                end else if (r == 15 && size_val < 64) begin
                    pending_items.push_back(make_item(ACT_START, 4'($urandom_range(15)),
                                                      8'($urandom_range(255))));
                end else begin
                    pending_items.push_back(make_item(ACT_DIGIT, 4'($urandom_range(9)),
                                                      8'($urandom_range(255))));
                    n++;
                end
            end
        end
        // Sample the table after the run, both ends of the index range among the reads.
        pending_items.push_back(make_item(ACT_READ, 4'($urandom_range(15)), 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'($urandom_range(15)), 8'd255));
        pending_items.push_back(make_item(ACT_READ, 4'($urandom_range(15)),
                                          8'($urandom_range(255))));
        pending_items.push_back(make_item(ACT_READ, 4'($urandom_range(15)),
                                          8'($urandom_range(255))));
    endtask

    // Stimulus sequence.
    initial begin
        restart_model();
        size_model = SIZE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity reads, single-digit draws, ignored digits and an unused action.
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd15, 8'd255));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd9, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd10, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd15, 8'd255));
        pending_items.push_back(make_item(ACT_NOP, 4'd15, 8'd255));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd9, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd8, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd5, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd2));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd3));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_START, 4'd15, 8'd255));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd2));

        // A size of zero acts as two; a digit after the finish is ignored.
        write_table_size(9'd0);
        pending_items.push_back(make_item(ACT_START, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd7, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd3, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd1));

        // The largest size acts as full depth, and the finished flag stays set.
        write_table_size(9'd511);
        pending_items.push_back(make_item(ACT_DIGIT, 4'd4, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_START, 4'd0, 8'd0));
        pending_items.push_back(make_item(ACT_DIGIT, 4'd1, 8'd0));

        // Lower the size below the position mid-shuffle, then raise it again.
        shuffle_phase(9'd50, 20);
        write_table_size(9'd4);
        pending_items.push_back(make_item(ACT_DIGIT, 4'd2, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd5));
        write_table_size(9'd200);
        pending_items.push_back(make_item(ACT_DIGIT, 4'd3, 8'd0));
        pending_items.push_back(make_item(ACT_READ, 4'd0, 8'd1));

        // Random shuffles over a spread of sizes, one without any idling.
        shuffle_phase(9'd1, 50);
        shuffle_phase(9'd2, 50);
        shuffle_phase(9'd3, 50);
        shuffle_phase(9'd10, 100);
        shuffle_phase(9'd11, 100);
        shuffle_phase(9'($urandom_range(40, 12)), 300);
        wait_drained();
        steady_run = 1'b1;
        shuffle_phase(9'($urandom_range(60, 20)), 400);
        wait_drained();
        steady_run = 1'b0;
        // Past position 99 the draws take three digits.
        shuffle_phase(9'd110, 600);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #9600000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dts_pkg.sv
rtl/core/dts_ctrl.sv
rtl/core/dts_dpath.sv
rtl/core/digit_driven_table_shuffle.sv
rtl/core/dts_checker.sv
tb/sv/testbench.sv
